// ----- rtl/shortest_job_first_multi_server_defines.svh -----
// assertion macros for the scheduler checker
`ifndef SHORTEST_JOB_FIRST_MULTI_SERVER_DEFINES_SVH
`define SHORTEST_JOB_FIRST_MULTI_SERVER_DEFINES_SVH
// assert that a implies b at the same edge
`define SJF_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b at the next edge
`define SJF_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ----- rtl/sjf_pkg.sv -----
// shared constants and types of the scheduler
package sjf_pkg;
    localparam int MaxCustomers = 32;
    localparam int MaxServers   = 8;
    localparam int TimeBits     = 16;
    localparam int CntBits      = $clog2(MaxCustomers + 1);
    localparam int AddrBits     = $clog2(MaxCustomers);
    localparam int SrvBits      = $clog2(MaxServers);
    localparam int FinBits      = 21;
    localparam int SumBits      = 26;
    localparam logic [3:0] ServerCountReset = 4'd2;

    typedef enum logic [3:0] {
        ST_LOAD, ST_SORT_RD, ST_SORT_WAIT, ST_SORT_CMP, ST_SORT_PUT, ST_PASS_RD,
        ST_PASS_WAIT, ST_PASS_ACC, ST_DIV, ST_OUT_RD, ST_OUT_WAIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic                          we;
        logic [AddrBits-1:0]           waddr;
        logic [TimeBits-1:0]           wdata;
        logic [AddrBits-1:0]           raddr;
    } t_mem_ctl;
endpackage

// ----- rtl/sjf_if.sv -----
// valid/ready channel interfaces of the scheduler
interface sjf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] service_time;
    logic        last_customer;
    modport source(output valid, service_time, last_customer, input ready);
    modport sink(input valid, service_time, last_customer, output ready);
endinterface

interface sjf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sorted_service_time;
    logic [2:0]  server_index;
    logic [20:0] finish_time;
    logic [20:0] average_wait;
    logic        last_result;
    modport source(output valid, sorted_service_time, server_index, finish_time,
                   average_wait, last_result, input ready);
    modport sink(input valid, sorted_service_time, server_index, finish_time,
                 average_wait, last_result, output ready);
endinterface

// ----- rtl/sjf_time_ram.sv -----
// customer time store, one write and one registered read port
module sjf_time_ram (
    input  logic                                   i_clk,
    input  sjf_pkg::t_mem_ctl                      i_ctl,
    output logic [sjf_pkg::TimeBits-1:0]           o_rdata
);
    import sjf_pkg::*;
    logic [TimeBits-1:0] r_mem [MaxCustomers];
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        o_rdata <= r_mem[i_ctl.raddr];
    end
endmodule

// ----- rtl/sjf_divider.sv -----
// restoring divider, one quotient bit per cycle
module sjf_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [sjf_pkg::SumBits-1:0]       i_num,
    input  logic [sjf_pkg::CntBits-1:0]       i_den,
    output logic                              o_done,
    output logic [sjf_pkg::SumBits-1:0]       o_quot
);
    import sjf_pkg::*;
    localparam int StepBits = $clog2(SumBits + 1);
    logic [SumBits-1:0]  r_q, n_q;
    logic [CntBits:0]    r_rem, n_rem;
    logic [CntBits-1:0]  r_den;
    logic [StepBits-1:0] r_cnt;
    logic                r_busy;
    logic [CntBits:0]    w_trial;

    always_comb begin
        w_trial = {r_rem[CntBits-1:0], r_q[SumBits-1]};
        n_q     = {r_q[SumBits-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem   = w_trial - {1'b0, r_den};
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= StepBits'(SumBits);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == StepBits'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule

// ----- rtl/shortest_job_first_multi_server.sv -----
// top level of the shortest-job-first multi-server scheduler
// channel | dir | payload                                             | handshake
// s_in    | in  | service_time, last_customer                         | valid/ready
// m_out   | out | sorted_service_time, server_index, finish_time,     | valid/ready
//         |     | average_wait, last_result                           |
// loading accepts one transaction per cycle; the closing transaction starts an
// in-memory insertion sort (per round: read, wait, compare with one shift
// per larger entry, and a put state when the key lands at the front), a read,
// wait and accumulate pass per customer for server assignment and the finish
// sum, the divide state and a read, wait and output pass per result;
// a batch of one customer skips the sort; all use the single ram read port
// reset is synchronous and active low, the time store has no clearing pass
// input ready is low from the closing transaction until the last result is taken
// output stalls simply hold the result register
module shortest_job_first_multi_server (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    sjf_in_if.sink      s_in,
    sjf_out_if.source   m_out
);
    import sjf_pkg::*;

    t_state r_state, n_state;
    logic [3:0]           r_srv_cfg;
    logic [CntBits-1:0]   r_count;
    logic [AddrBits-1:0]  r_i, r_j;            // sort round index / hole for the key
    logic [TimeBits-1:0]  r_key;               // value being inserted
    logic [CntBits-1:0]   r_k;                 // pass index
    logic [FinBits-1:0]   r_free [MaxServers];
    logic [SumBits-1:0]   r_sum;
    logic [FinBits-1:0]   r_avg;
    logic [SrvBits-1:0]   r_nsrv_m1;
    logic [TimeBits-1:0]  w_rdata;
    t_mem_ctl             w_ctl;
    logic                 w_div_start, w_div_done;
    logic [SumBits-1:0]   w_quot;
    logic [SrvBits-1:0]   w_best;
    logic [FinBits-1:0]   w_fin;
    logic [FinBits-1:0]   w_out_fin [MaxCustomers];
    logic [SrvBits-1:0]   w_out_srv [MaxCustomers];
    logic [FinBits-1:0]   r_fin_tab [MaxCustomers];
    logic [SrvBits-1:0]   r_srv_tab [MaxCustomers];
    logic [AddrBits-1:0]  w_k_addr;
    logic                 w_in_acc;
    logic [CntBits-1:0]   w_load_cnt;
    logic                 w_sort_last;

    assign w_in_acc = s_in.valid && s_in.ready;
    assign s_in.ready = (r_state == ST_LOAD);
    assign w_k_addr = r_k[AddrBits-1:0];
    assign w_out_fin = r_fin_tab;
    assign w_out_srv = r_srv_tab;
    // a full store keeps its count, the extra time is dropped
    assign w_load_cnt = (r_count < CntBits'(MaxCustomers)) ? r_count + 1'b1 : r_count;
    assign w_sort_last = ({1'b0, r_i} + 1'b1 == r_count);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srv_cfg <= ServerCountReset;
        end else if (i_cfg_we) begin
            r_srv_cfg <= i_cfg_wdata;
        end
    end

    // earliest free server, lowest index wins ties
    always_comb begin
        w_best = '0;
        for (int s = 1; s < MaxServers; s++) begin
            if (SrvBits'(s) <= r_nsrv_m1 && r_free[s] < r_free[w_best]) begin
                w_best = SrvBits'(s);
            end
        end
        w_fin = r_free[w_best] + FinBits'(w_rdata);
    end

    // ram control
    always_comb begin
        w_ctl.we    = 1'b0;
        w_ctl.waddr = r_count[AddrBits-1:0];
        w_ctl.wdata = s_in.service_time[TimeBits-1:0];
        w_ctl.raddr = w_k_addr;
        unique case (r_state)
            ST_LOAD: begin
                w_ctl.we = w_in_acc && (r_count < CntBits'(MaxCustomers));
            end
            ST_SORT_RD: w_ctl.raddr = r_i;
            ST_SORT_WAIT: w_ctl.raddr = r_j - 1'b1;
            ST_SORT_CMP: begin
                // shift the larger entry into the hole, or drop the key there
                w_ctl.we    = 1'b1;
                w_ctl.waddr = r_j;
                w_ctl.wdata = r_key;
                w_ctl.raddr = r_j - 2'd2;
                if (w_rdata > r_key) begin
                    w_ctl.wdata = w_rdata;
                end
            end
            ST_SORT_PUT: begin
                // key belongs at the front
                w_ctl.we    = 1'b1;
                w_ctl.waddr = r_j;
                w_ctl.wdata = r_key;
            end
            default: ;
        endcase
    end

    sjf_time_ram u_ram (.i_clk(i_clk), .i_ctl(w_ctl), .o_rdata(w_rdata));

    assign w_div_start = (r_state == ST_PASS_ACC) && (r_k + 1'b1 == r_count);
    sjf_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(r_sum + SumBits'(w_fin)), .i_den(r_count),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && s_in.last_customer) begin
                    n_state = (w_load_cnt <= CntBits'(1)) ? ST_PASS_RD : ST_SORT_RD;
                end
            end
            ST_SORT_RD:   n_state = ST_SORT_WAIT;
            ST_SORT_WAIT: n_state = ST_SORT_CMP;
            ST_SORT_CMP: begin
                if (w_rdata > r_key) begin
                    n_state = (r_j == AddrBits'(1)) ? ST_SORT_PUT : ST_SORT_CMP;
                end else begin
                    n_state = w_sort_last ? ST_PASS_RD : ST_SORT_RD;
                end
            end
            ST_SORT_PUT:  n_state = w_sort_last ? ST_PASS_RD : ST_SORT_RD;
            ST_PASS_RD:   n_state = ST_PASS_WAIT;
            ST_PASS_WAIT: n_state = ST_PASS_ACC;
            ST_PASS_ACC:  n_state = (r_k + 1'b1 == r_count) ? ST_DIV : ST_PASS_RD;
            ST_DIV:       if (w_div_done) n_state = ST_OUT_RD;
            ST_OUT_RD:    n_state = ST_OUT_WAIT;
            ST_OUT_WAIT:  n_state = ST_OUT;
            ST_OUT:       if (m_out.ready) begin
                n_state = m_out.last_result ? ST_LOAD : ST_OUT_RD;
            end
            default:      n_state = ST_LOAD;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            m_out.valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        r_count <= w_load_cnt;
                        if (s_in.last_customer) begin
                            r_i <= AddrBits'(1);
                            r_k <= '0;
                            r_sum <= '0;
                            for (int s = 0; s < MaxServers; s++) r_free[s] <= '0;
                            if (r_srv_cfg == 4'd0) r_nsrv_m1 <= '0;
                            else if (r_srv_cfg > 4'(MaxServers)) begin
                                r_nsrv_m1 <= SrvBits'(MaxServers - 1);
                            end else r_nsrv_m1 <= SrvBits'(r_srv_cfg - 4'd1);
                        end
                    end
                end
                ST_SORT_RD: r_j <= r_i;
                ST_SORT_WAIT: r_key <= w_rdata;
                ST_SORT_CMP: begin
                    if (w_rdata > r_key) begin
                        r_j <= r_j - 1'b1;
                    end else if (!w_sort_last) begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_SORT_PUT: begin
                    if (!w_sort_last) r_i <= r_i + 1'b1;
                end
                ST_PASS_ACC: begin
                    r_free[w_best]      <= w_fin;
                    r_sum               <= r_sum + SumBits'(w_fin);
                    r_fin_tab[w_k_addr] <= w_fin;
                    r_srv_tab[w_k_addr] <= w_best;
                    r_k                 <= r_k + 1'b1;
                end
                ST_DIV: begin
                    r_avg <= w_quot[FinBits-1:0];
                    r_k   <= '0;
                end
                ST_OUT_WAIT: begin
                    m_out.valid               <= 1'b1;
                    m_out.sorted_service_time <= w_rdata;
                    m_out.server_index        <= w_out_srv[w_k_addr];
                    m_out.finish_time         <= w_out_fin[w_k_addr];
                    m_out.average_wait        <= r_avg;
                    m_out.last_result         <= (r_k + 1'b1 == r_count);
                end
                ST_OUT: begin
                    if (m_out.ready) begin
                        m_out.valid <= 1'b0;
                        r_k <= r_k + 1'b1;
                        if (m_out.last_result) r_count <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- rtl/sjf_checker.sv -----
// port-level checker for the scheduler and its bind
`include "shortest_job_first_multi_server_defines.svh"
module sjf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last
);
    // no loading while results are pending
    `SJF_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, out_valid, !in_ready)
    // a stalled result stays
    `SJF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    // after the last result the block loads again
    `SJF_ASSERT_NEXT(a_reload, i_clk, i_rst_n, out_valid && out_ready && out_last, in_ready)
endmodule

bind shortest_job_first_multi_server sjf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready), .out_last(m_out.last_result)
);
